@@ rtl/cmdlf_pkg.sv @@
// Shared types, constants and saturating arithmetic helpers for the
// leapfrog chain integrator. No dependencies.
package cmdlf_pkg;

   localparam int FRAC_BITS = 24;
   localparam int POS_W     = 37;
   localparam int VEL_W     = 40;
   localparam int BOX_W     = 37;

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_ADVANCE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   localparam logic [2:0] CSR_ATOM_COUNT  = 3'd0;
   localparam logic [2:0] CSR_BOX_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_REST_LENGTH = 3'd2;
   localparam logic [2:0] CSR_SPRING_K1   = 3'd3;
   localparam logic [2:0] CSR_SPRING_K2   = 3'd4;
   localparam logic [2:0] CSR_TIME_STEP   = 3'd5;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [65:0] V40_MAX = 66'sh00_0000_007F_FFFF_FFFF;
   localparam logic signed [65:0] V40_MIN = -66'sh00_0000_0080_0000_0000;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [11:0]        atom_index;
      logic [35:0]        load_position;
      logic signed [39:0] load_velocity;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] potential_sum;
      logic [62:0]        kinetic_sum;
      logic [35:0]        read_position;
      logic signed [39:0] read_velocity;
   } rsp_word_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_DATA, ST_RESP,
      ST_A_RD, ST_A_SH, ST_A_DIFF,
      ST_MUL_GO, ST_MUL_WT,
      ST_SUM1, ST_SUM2, ST_SUM3,
      ST_B_RD, ST_B_DAT, ST_B_V1, ST_B_X, ST_B_W, ST_B_EK,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_SL, OP_SR, OP_CL, OP_CR, OP_KS, OP_KC, OP_KD, OP_KQ,
      OP_DA, OP_DV, OP_VV
   } mul_op_type;

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sneg64(input logic signed [63:0] a);
      if (a == S64_MIN) begin
         return S64_MAX;
      end
      return -a;
   endfunction

   // halve, truncating toward zero
   function automatic logic signed [63:0] half64(input logic signed [63:0] a);
      logic signed [64:0] y;
      y = 65'(a) + 65'({64'd0, a[63]});
      return y[64:1];
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [65:0] x);
      if (x > V40_MAX) begin
         return 40'sh7F_FFFF_FFFF;
      end else if (x < V40_MIN) begin
         return 40'sh80_0000_0000;
      end
      return x[39:0];
   endfunction

   // minimum image of a bond difference
   function automatic logic signed [40:0] image41(input logic signed [40:0] d,
                                                  input logic [36:0] box);
      logic signed [41:0] d2;
      logic signed [41:0] bx;
      d2 = {d, 1'b0};
      bx = $signed(42'(box));
      if (d2 < -bx) begin
         return d + $signed(41'(box));
      end else if (d2 >= bx) begin
         return d - $signed(41'(box));
      end
      return d;
   endfunction

endpackage

@@ rtl/cmdlf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cmdlf_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cmdlf_mul.sv @@
// Multi-cycle signed 64x64 fixed-point multiplier: one 32x32 partial product
// per cycle, truncated magnitude, saturated to 64 bits. Uses cmdlf_pkg.
module cmdlf_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  cmdlf_pkg::mul_req_type mreq,
   output cmdlf_pkg::mul_rsp_type mrsp
);
   import cmdlf_pkg::*;

   logic [63:0]        mag_a_ff;
   logic [63:0]        mag_b_ff;
   logic               neg_ff;
   logic [127:0]       acc_ff;
   logic [1:0]         step_ff;
   logic               run_ff;
   logic               fin_ff;
   logic               done_ff;
   logic signed [63:0] res_ff;

   logic [31:0]  half_a;
   logic [31:0]  half_b;
   logic [63:0]  pp;
   logic [1:0]   shift_sel;
   logic [127:0] pp_shifted;
   logic [63:0]  rlo;
   logic         rhi_nz;
   logic [63:0]  lim;
   logic [63:0]  mag;
   logic [63:0]  res_in;

   always_comb begin
      half_a    = step_ff[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      half_b    = step_ff[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      pp        = half_a * half_b;
      shift_sel = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      case (shift_sel)
         2'd0:    pp_shifted = {64'd0, pp};
         2'd1:    pp_shifted = {32'd0, pp, 32'd0};
         2'd2:    pp_shifted = {pp, 64'd0};
         default: pp_shifted = '0;
      endcase
      rlo    = acc_ff[FRAC_BITS+63:FRAC_BITS];
      rhi_nz = |acc_ff[127:FRAC_BITS+64];
      lim    = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      mag    = (rhi_nz || rlo > lim) ? lim : rlo;
      res_in = neg_ff ? (64'd0 - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mreq.start) begin
            mag_a_ff <= mreq.a[63] ? 64'd0 - mreq.a : mreq.a;
            mag_b_ff <= mreq.b[63] ? 64'd0 - mreq.b : mreq.b;
            neg_ff   <= mreq.a[63] ^ mreq.b[63];
            acc_ff   <= '0;
            step_ff  <= '0;
            run_ff   <= 1'b1;
         end else if (run_ff) begin
            acc_ff  <= acc_ff + pp_shifted;
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end else if (fin_ff) begin
            res_ff  <= res_in;
            done_ff <= 1'b1;
            fin_ff  <= 1'b0;
         end
      end
   end

   assign mrsp.done   = done_ff;
   assign mrsp.result = res_ff;

endmodule

@@ rtl/chain_md_leapfrog_step_unit.sv @@
// Top level of the leapfrog chain integrator: request/result channels,
// register port, atom stores and the step sequencer.
// Uses cmdlf_pkg, cmdlf_ram and cmdlf_mul.
//
// Usage:
//   req_* carries one request word (load atom, advance one step, read atom);
//   a word is taken when req_valid is high and req_stall is low. Every
//   request gives exactly one rsp_* word, taken when rsp_valid is high and
//   rsp_stall is low. csr_* writes one register per handshake; csr_ready is
//   always high, write only while no request is in flight.
// Operation:
//   load: result straight to the output register; read: after a store read.
//   advance (n = atom_count, clamped): a bond pass over the n atoms after
//   priming the neighbor window, then an update pass. Both passes run on
//   the shared multi-cycle multiplier (8 products per bond, 3 per update).
//   One request is worked at a time; the next is taken once the result sits
//   in the output register, which holds while rsp_stall is high.
// Reset: registers return to their defaults, the output register empties.
//   Atom stores are not cleared; read only atoms that were loaded.
module chain_md_leapfrog_step_unit #(
   parameter int MAX_ATOMS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cmdlf_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cmdlf_pkg::rsp_word_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [63:0]             csr_wdata
);
   import cmdlf_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ATOMS);
   localparam int CNT_W  = $clog2(MAX_ATOMS + 1);

   logic [12:0]        atom_count_ff;
   logic [36:0]        box_length_ff;
   logic [26:0]        rest_length_ff;
   logic [28:0]        spring_k1_ff;
   logic [29:0]        spring_k2_ff;
   logic [24:0]        time_step_ff;

   state_type          state_ff, state_in;
   mul_op_type         op_ff;
   logic [CNT_W-1:0]   ai_ff;
   logic [ADDR_W-1:0]  rp_ff;
   logic [1:0]         prime_ff;
   logic               rd_ok_ff;
   logic [36:0]        xl_ff, xc_ff, xr_ff, x0_ff;
   logic signed [40:0] dl_ff, dr_ff;
   logic signed [63:0] sl_ff, sr_ff, cl_ff, cr_ff, p1_ff, p2_ff, t1_ff, t2_ff;
   logic signed [63:0] ep_ff, ek_ff;
   logic signed [39:0] v0_ff, av_ff, v1_ff, va_ff;
   logic signed [65:0] xs_ff;
   rsp_word_type       res_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   last_idx;
   logic [36:0]        box_eff;
   logic [31:0]        ac32;
   logic [31:0]        idx32;
   logic               idx_ok;
   logic [ADDR_W-1:0]  req_addr;
   logic               req_acc;
   logic               out_free;

   logic                     st_we, acc_we;
   logic [ADDR_W-1:0]        st_wa, st_ra;
   logic [POS_W+VEL_W-1:0]   st_wd, st_rd;
   logic [36:0]              pos_rd;
   logic [39:0]              vel_rd, acc_wd, acc_rd;

   mul_req_type        mreq;
   mul_rsp_type        mrsp;

   logic signed [40:0] dfl, dfr;
   logic signed [65:0] box66;
   logic signed [65:0] wx;
   logic signed [40:0] vsum;
   logic signed [63:0] sum3;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         atom_count_ff  <= 13'd4096;
         box_length_ff  <= 37'h10_0000_0000;
         rest_length_ff <= 27'd16777216;
         spring_k1_ff   <= 29'd16777216;
         spring_k2_ff   <= 30'd1677722;
         time_step_ff   <= 25'd167772;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ATOM_COUNT:  atom_count_ff  <= csr_wdata[12:0];
            CSR_BOX_LENGTH:  box_length_ff  <= csr_wdata[36:0];
            CSR_REST_LENGTH: rest_length_ff <= csr_wdata[26:0];
            CSR_SPRING_K1:   spring_k1_ff   <= csr_wdata[28:0];
            CSR_SPRING_K2:   spring_k2_ff   <= csr_wdata[29:0];
            CSR_TIME_STEP:   time_step_ff   <= csr_wdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ac32 = 32'(atom_count_ff);
      if (ac32 < 32'd2) begin
         n_eff = CNT_W'(2);
      end else if (ac32 > 32'(MAX_ATOMS)) begin
         n_eff = CNT_W'(MAX_ATOMS);
      end else begin
         n_eff = CNT_W'(ac32);
      end
      last_idx = n_eff - CNT_W'(1);
      if (box_length_ff == 37'd0) begin
         box_eff = 37'd1;
      end else if (box_length_ff > 37'h10_0000_0000) begin
         box_eff = 37'h10_0000_0000;
      end else begin
         box_eff = box_length_ff;
      end
      box66    = $signed(66'(box_eff));
      idx32    = 32'(req_data.atom_index);
      idx_ok   = idx32 < 32'(MAX_ATOMS);
      req_addr = idx32[ADDR_W-1:0];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // datapath helpers
   always_comb begin
      dfl  = $signed(41'(xc_ff)) - $signed(41'(xl_ff));
      dfr  = $signed(41'(xr_ff)) - $signed(41'(xc_ff));
      vsum = 41'(v0_ff) + 41'(v1_ff);
      sum3 = sadd64(t1_ff, p2_ff);
      wx   = xs_ff;
      if (wx < 66'sd0) begin
         wx = wx + box66;
      end else if (wx >= box66) begin
         wx = wx - box66;
      end
      if (wx < 66'sd0) begin
         wx = 66'sd0;
      end
      if (wx >= box66) begin
         wx = box66 - 66'sd1;
      end
   end

   // multiplier operand select
   always_comb begin
      mreq.start = (state_ff == ST_MUL_GO);
      case (op_ff)
         OP_SL: begin mreq.a = 64'(dl_ff); mreq.b = 64'(dl_ff); end
         OP_SR: begin mreq.a = 64'(dr_ff); mreq.b = 64'(dr_ff); end
         OP_CL: begin mreq.a = sl_ff; mreq.b = 64'(dl_ff); end
         OP_CR: begin mreq.a = sr_ff; mreq.b = 64'(dr_ff); end
         OP_KS: begin
            mreq.a = $signed(64'(spring_k1_ff));
            mreq.b = sadd64(sl_ff, sr_ff);
         end
         OP_KC: begin
            mreq.a = 64'($signed(spring_k2_ff));
            mreq.b = sadd64(cl_ff, cr_ff);
         end
         OP_KD: begin
            mreq.a = $signed(64'(spring_k1_ff));
            mreq.b = 64'(dl_ff) - 64'(dr_ff);
         end
         OP_KQ: begin
            mreq.a = 64'($signed(spring_k2_ff));
            mreq.b = sadd64(sl_ff, sneg64(sr_ff));
         end
         OP_DA: begin mreq.a = $signed(64'(time_step_ff)); mreq.b = 64'(av_ff); end
         OP_DV: begin mreq.a = $signed(64'(time_step_ff)); mreq.b = 64'(v1_ff); end
         OP_VV: begin mreq.a = 64'(va_ff); mreq.b = 64'(va_ff); end
         default: begin mreq.a = '0; mreq.b = '0; end
      endcase
   end

   // memory ports
   always_comb begin
      st_we  = 1'b0;
      acc_we = 1'b0;
      st_wa  = req_addr;
      st_wd  = {37'(req_data.load_position), req_data.load_velocity};
      acc_wd = sat40(66'(sneg64(sum3)));
      st_ra  = req_addr;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.req_type == REQ_LOAD && idx_ok) begin
               st_we = 1'b1;
            end
         end
         ST_A_RD: st_ra = rp_ff;
         ST_SUM3: acc_we = 1'b1;
         ST_B_RD: st_ra = ai_ff[ADDR_W-1:0];
         ST_B_W: begin
            st_we = 1'b1;
            st_wa = ai_ff[ADDR_W-1:0];
            st_wd = {wx[36:0], v1_ff};
         end
         default: ;
      endcase
   end

   assign pos_rd = st_rd[POS_W+VEL_W-1:VEL_W];
   assign vel_rd = st_rd[VEL_W-1:0];

   cmdlf_ram #(.WIDTH(POS_W + VEL_W), .DEPTH(MAX_ATOMS)) u_state_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   cmdlf_ram #(.WIDTH(VEL_W), .DEPTH(MAX_ATOMS)) u_acc_ram (
      .clock(clock), .wr_en(acc_we), .wr_addr(ai_ff[ADDR_W-1:0]), .wr_data(acc_wd),
      .rd_addr(ai_ff[ADDR_W-1:0]), .rd_data(acc_rd)
   );

   cmdlf_mul u_mul (
      .clock(clock),
      .reset(reset),
      .mreq(mreq),
      .mrsp(mrsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.req_type)
                  REQ_ADVANCE: state_in = ST_A_RD;
                  REQ_READ:    state_in = ST_RD_DATA;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_RD_DATA: state_in = ST_RESP;
         ST_RESP:    state_in = out_free ? ST_IDLE : ST_RESP;
         ST_A_RD:    state_in = ST_A_SH;
         ST_A_SH:    state_in = (prime_ff == 2'd2) ? ST_A_DIFF : ST_A_RD;
         ST_A_DIFF:  state_in = ST_MUL_GO;
         ST_MUL_GO:  state_in = ST_MUL_WT;
         ST_MUL_WT: begin
            if (mrsp.done) begin
               case (op_ff)
                  OP_KQ:   state_in = ST_SUM1;
                  OP_DA:   state_in = ST_B_V1;
                  OP_DV:   state_in = ST_B_X;
                  OP_VV:   state_in = ST_B_EK;
                  default: state_in = ST_MUL_GO;
               endcase
            end
         end
         ST_SUM1:  state_in = ST_SUM2;
         ST_SUM2:  state_in = ST_SUM3;
         ST_SUM3:  state_in = (ai_ff == last_idx) ? ST_B_RD : ST_A_RD;
         ST_B_RD:  state_in = ST_B_DAT;
         ST_B_DAT: state_in = ST_MUL_GO;
         ST_B_V1:  state_in = ST_MUL_GO;
         ST_B_X:   state_in = ST_B_W;
         ST_B_W:   state_in = ST_MUL_GO;
         ST_B_EK:  state_in = (ai_ff == last_idx) ? ST_FIN : ST_B_RD;
         ST_FIN:   state_in = ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_SL;
         ai_ff    <= '0;
         rp_ff    <= '0;
         prime_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  res_ff   <= '0;
                  rd_ok_ff <= idx_ok;
                  ep_ff    <= '0;
                  ek_ff    <= '0;
                  ai_ff    <= '0;
                  rp_ff    <= last_idx[ADDR_W-1:0];
                  prime_ff <= '0;
               end
            end
            ST_RD_DATA: begin
               if (rd_ok_ff) begin
                  res_ff.read_position <= pos_rd[35:0];
                  res_ff.read_velocity <= vel_rd;
               end
            end
            ST_A_RD: begin
               rp_ff <= (rp_ff == last_idx[ADDR_W-1:0]) ? '0 : rp_ff + ADDR_W'(1);
            end
            ST_A_SH: begin
               xl_ff <= xc_ff;
               xc_ff <= xr_ff;
               xr_ff <= pos_rd;
               if (prime_ff != 2'd2) begin
                  prime_ff <= prime_ff + 2'd1;
               end
            end
            ST_A_DIFF: begin
               dl_ff <= image41(dfl, box_eff) - $signed(41'(rest_length_ff));
               dr_ff <= image41(dfr, box_eff) - $signed(41'(rest_length_ff));
               op_ff <= OP_SL;
            end
            ST_MUL_WT: begin
               if (mrsp.done) begin
                  case (op_ff)
                     OP_SL: begin sl_ff <= mrsp.result; op_ff <= OP_SR; end
                     OP_SR: begin sr_ff <= mrsp.result; op_ff <= OP_CL; end
                     OP_CL: begin cl_ff <= mrsp.result; op_ff <= OP_CR; end
                     OP_CR: begin cr_ff <= mrsp.result; op_ff <= OP_KS; end
                     OP_KS: begin p1_ff <= mrsp.result; op_ff <= OP_KC; end
                     OP_KC: begin p2_ff <= mrsp.result; op_ff <= OP_KD; end
                     OP_KD: begin t1_ff <= mrsp.result; op_ff <= OP_KQ; end
                     OP_KQ: t2_ff <= mrsp.result;
                     OP_DA: t1_ff <= mrsp.result;
                     OP_DV: t2_ff <= mrsp.result;
                     OP_VV: p1_ff <= mrsp.result;
                     default: ;
                  endcase
               end
            end
            ST_SUM1: begin
               p1_ff <= half64(sadd64(p1_ff, p2_ff));
               t1_ff <= sadd64(t1_ff, t1_ff);
               p2_ff <= sadd64(t2_ff, t2_ff);
            end
            ST_SUM2: begin
               p2_ff <= sadd64(p2_ff, t2_ff);
               ep_ff <= sadd64(ep_ff, p1_ff);
            end
            ST_SUM3: begin
               ai_ff <= (ai_ff == last_idx) ? '0 : ai_ff + CNT_W'(1);
            end
            ST_B_DAT: begin
               v0_ff <= vel_rd;
               av_ff <= acc_rd;
               x0_ff <= pos_rd;
               op_ff <= OP_DA;
            end
            ST_B_V1: begin
               v1_ff <= sat40(66'(v0_ff) + 66'(t1_ff));
               op_ff <= OP_DV;
            end
            ST_B_X: begin
               xs_ff <= $signed(66'(x0_ff)) + 66'(t2_ff);
               va_ff <= vsum[40:1] + 40'(vsum[40] & vsum[0]);
            end
            ST_B_W: op_ff <= OP_VV;
            ST_B_EK: begin
               ek_ff <= sadd64(ek_ff, p1_ff >>> 1);
               ai_ff <= ai_ff + CNT_W'(1);
            end
            ST_FIN: begin
               res_ff.potential_sum <= ep_ff;
               res_ff.kinetic_sum   <= ek_ff[62:0];
            end
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_RESP && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= res_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> state_ff == ST_MUL_WT)
      else $error("multiplier result with no product pending");

   a_accel_in_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM3 |-> ai_ff < n_eff)
      else $error("acceleration written beyond ring");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result word loaded outside response state");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("request taken while another is in flight");

endmodule

@@ dv/chain_md_leapfrog_step_unit_tb.sv @@
// Self-checking testbench for the leapfrog chain integrator top level.
// Drives load, advance, read and undefined request words with an in-bench fixed-point predictor.
// Depends on rtl/cmdlf_pkg.sv and the chain_md_leapfrog_step_unit RTL.
`timescale 1ns / 100ps

module chain_md_leapfrog_step_unit_tb;
   import cmdlf_pkg::*;

   localparam int  ATOMS       = 4096;
   localparam int  IDLE_LIMIT  = 20000;
   localparam longint ONE_Q    = 64'sd16777216;
   localparam longint BOX_TOP  = 64'sd68719476736;
   localparam longint VEL_TOP  = 64'sd549755813887;
   localparam longint VEL_BOT  = -64'sd549755813888;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   chain_md_leapfrog_step_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   longint       pos_mem[ATOMS];
   longint       vel_mem[ATOMS];
   longint       acc_mem[ATOMS];
   bit           loaded[ATOMS];
   logic [12:0]  reg_count;
   logic [36:0]  reg_box;
   logic [26:0]  reg_rest;
   logic [28:0]  reg_k1;
   logic [29:0]  reg_k2;
   logic [24:0]  reg_dt;

   rsp_word_type energy_q[$];
   int           error_count = 0;
   int           burst_left;
   int           idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return s[63:0];
   endfunction

   function automatic longint sat_neg(longint a);
      if (a == 64'sh8000_0000_0000_0000) begin
         return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      return -a;
   endfunction

   function automatic longint clip_vel(longint a);
      if (a > VEL_TOP) begin
         return VEL_TOP;
      end else if (a < VEL_BOT) begin
         return VEL_BOT;
      end
      return a;
   endfunction

   function automatic longint fixed_mul(longint a, longint b);
      logic         neg;
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [63:0]  lim;
      logic [63:0]  mag;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      mag = (p[127:64] != 0 || p[63:0] > lim) ? lim : p[63:0];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic longint ring_image(longint d, longint box);
      if (2 * d < -box) begin
         return d + box;
      end else if (2 * d >= box) begin
         return d - box;
      end
      return d;
   endfunction

   function automatic void step_ring(output longint ep, output longint ek);
      int     n;
      longint box, rest, k1, k2, dt;
      longint dl, dr, sl, sr, cl, cr, u, t1, t2, s, v0, v1, x, va;
      n    = (reg_count < 2) ? 2 : ((reg_count > ATOMS) ? ATOMS : int'(reg_count));
      box  = (reg_box == 0) ? 1 : ((reg_box > BOX_TOP) ? BOX_TOP : longint'(reg_box));
      rest = longint'(reg_rest);
      k1   = longint'(reg_k1);
      k2   = longint'($signed(reg_k2));
      dt   = longint'(reg_dt);
      ep   = 0;
      ek   = 0;
      for (int i = 0; i < n; i++) begin
         x  = pos_mem[i];
         dl = ring_image(x - pos_mem[(i == 0) ? n - 1 : i - 1], box) - rest;
         dr = ring_image(pos_mem[(i + 1 >= n) ? 0 : i + 1] - x, box) - rest;
         sl = fixed_mul(dl, dl);
         sr = fixed_mul(dr, dr);
         cl = fixed_mul(sl, dl);
         cr = fixed_mul(sr, dr);
         u  = sat_add(fixed_mul(k1, sat_add(sl, sr)), fixed_mul(k2, sat_add(cl, cr))) / 2;
         t1 = fixed_mul(k1, dl - dr);
         t2 = fixed_mul(k2, sat_add(sl, sat_neg(sr)));
         s  = sat_add(sat_add(t1, t1), sat_add(sat_add(t2, t2), t2));
         acc_mem[i] = clip_vel(sat_neg(s));
         ep = sat_add(ep, u);
      end
      for (int i = 0; i < n; i++) begin
         v0 = vel_mem[i];
         v1 = clip_vel(v0 + fixed_mul(dt, acc_mem[i]));
         x  = pos_mem[i] + fixed_mul(dt, v1);
         if (x < 0) begin
            x += box;
         end else if (x >= box) begin
            x -= box;
         end
         if (x < 0) begin
            x = 0;
         end
         if (x >= box) begin
            x = box - 1;
         end
         vel_mem[i] = v1;
         pos_mem[i] = x;
         va = (v0 + v1) / 2;
         ek = sat_add(ek, fixed_mul(va, va) / 2);
      end
   endfunction

   function automatic rsp_word_type chain_predict(req_word_type w);
      rsp_word_type r;
      longint       ep, ek;
      r = '0;
      case (w.req_type)
         REQ_LOAD: begin
            pos_mem[w.atom_index] = longint'(w.load_position);
            vel_mem[w.atom_index] = longint'(w.load_velocity);
         end
         REQ_ADVANCE: begin
            step_ring(ep, ek);
            r.potential_sum = ep;
            r.kinetic_sum   = ek[62:0];
         end
         REQ_READ: begin
            r.read_position = pos_mem[w.atom_index][35:0];
            r.read_velocity = vel_mem[w.atom_index][39:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (energy_q.size() == 0) begin
            $error("unexpected response word %h", rsp_data);
            error_count++;
         end else begin
            want = energy_q.pop_front();
            if (rsp_data.potential_sum !== want.potential_sum) begin
               $error("potential_sum exp %0d got %0d", want.potential_sum,
                      rsp_data.potential_sum);
               error_count++;
            end
            if (rsp_data.kinetic_sum !== want.kinetic_sum) begin
               $error("kinetic_sum exp %0d got %0d", want.kinetic_sum,
                      rsp_data.kinetic_sum);
               error_count++;
            end
            if (rsp_data.read_position !== want.read_position) begin
               $error("read_position exp %h got %h", want.read_position,
                      rsp_data.read_position);
               error_count++;
            end
            if (rsp_data.read_velocity !== want.read_velocity) begin
               $error("read_velocity exp %h got %h", want.read_velocity,
                      rsp_data.read_velocity);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int mode, left;
      if (left <= 0) begin
         mode = $urandom_range(0, 2);
         left = $urandom_range(10, 200);
      end
      left--;
      case (mode)
         0:       rsp_stall = 1'b0;
         1:       rsp_stall = ($urandom_range(0, 1) == 1);
         default: rsp_stall = ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // all tasks begin and end at a falling edge
   task automatic send_word(req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.req_type == REQ_LOAD) begin
         loaded[w.atom_index] = 1'b1;
      end
      energy_q = {energy_q, chain_predict(w)};
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (energy_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, longint value);
      drain();
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ATOM_COUNT:  reg_count = value[12:0];
         CSR_BOX_LENGTH:  reg_box   = value[36:0];
         CSR_REST_LENGTH: reg_rest  = value[26:0];
         CSR_SPRING_K1:   reg_k1    = value[28:0];
         CSR_SPRING_K2:   reg_k2    = value[29:0];
         CSR_TIME_STEP:   reg_dt    = value[24:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_atom(int idx, longint x, longint v);
      req_word_type w;
      w = '0;
      w.req_type      = REQ_LOAD;
      w.atom_index    = 12'(idx);
      w.load_position = 36'(x);
      w.load_velocity = 40'(v);
      send_word(w);
   endtask

   task automatic issue(logic [1:0] kind, int idx);
      req_word_type w;
      w.req_type      = kind;
      w.atom_index    = 12'(idx);
      w.load_position = 36'(rand64());
      w.load_velocity = 40'(rand64());
      send_word(w);
   endtask

   task automatic set_ring(longint n, longint box, longint rest,
                           longint k1, longint k2, longint dt);
      write_reg(CSR_ATOM_COUNT, n);
      write_reg(CSR_BOX_LENGTH, box);
      write_reg(CSR_REST_LENGTH, rest);
      write_reg(CSR_SPRING_K1, k1);
      write_reg(CSR_SPRING_K2, k2);
      write_reg(CSR_TIME_STEP, dt);
   endtask

   task automatic test_load_read();
      set_ring(64'sd3, 3 * ONE_Q, ONE_Q, ONE_Q, 64'sd1677722, 64'sd167772);
      load_atom(0, 36'd0, 40'h80_0000_0000);
      load_atom(4095, 36'hF_FFFF_FFFF, 40'h7F_FFFF_FFFF);
      load_atom(1, ONE_Q, 40'hFF_FFFF_FFFF);
      load_atom(2, 2 * ONE_Q, 40'd0);
      issue(REQ_READ, 0);
      issue(REQ_READ, 4095);
      issue(REQ_READ, 1);
      issue(2'd3, 7);
      load_atom(4095, 36'd0, 40'd0);
      issue(REQ_READ, 4095);
   endtask

   task automatic test_advance_edges();
      // atom count below range, box of 2.0
      set_ring(64'sd0, 64'sd33554432, 64'sd0, ONE_Q, 64'sd1677722, 64'sd167772);
      load_atom(0, 36'd1000, 40'h00_0100_0000);
      load_atom(1, ONE_Q + 36'd5, 40'hFF_FF00_0000);
      issue(REQ_ADVANCE, 0);
      issue(REQ_READ, 0);
      issue(REQ_READ, 1);
      // runaway position outside the box, time step extremes
      set_ring(64'sd3, 3 * ONE_Q, 64'sd67108864, 64'sd0, 64'sd268435456, 64'sd16777216);
      load_atom(2, 36'hF_FFFF_FFFF, 40'h7F_FFFF_FFFF);
      issue(REQ_ADVANCE, 0);
      issue(REQ_READ, 2);
      write_reg(CSR_TIME_STEP, 64'sd1);
      issue(REQ_ADVANCE, 0);
      // saturating energies, oversized box, box of zero
      set_ring(64'sd2, 64'h1F_FFFF_FFFF, 64'sd67108864, 64'sd268435456,
               64'hFFFF_FFFF_F000_0000, 64'sd16777216);
      load_atom(0, 36'd0, 40'h7F_FFFF_FFFF);
      load_atom(1, 36'h8_0000_0000, 40'h80_0000_0000);
      issue(REQ_ADVANCE, 0);
      write_reg(CSR_SPRING_K2, 64'sd268435456);
      issue(REQ_ADVANCE, 0);
      write_reg(CSR_BOX_LENGTH, 64'sd0);
      issue(REQ_ADVANCE, 0);
      issue(REQ_READ, 1);
   endtask

   task automatic test_random_rings();
      int     n, pick, idx;
      longint box;
      for (int phase = 0; phase < 6; phase++) begin
         n   = $urandom_range(2, 8);
         box = ($urandom_range(0, 2) == 0) ?
               longint'($urandom_range(33554432, 32'hFFFF_FFFF)) : n * ONE_Q;
         set_ring(longint'(n), box, longint'($urandom_range(0, 67108864)),
                  longint'($urandom_range(0, 268435456)),
                  64'($signed($urandom_range(0, 536870912)) - 268435456),
                  longint'($urandom_range(1, 1 << 20)));
         for (int i = 0; i < n; i++) begin
            load_atom(i, (i * box / n + $urandom_range(0, 1 << 22)) % box,
                      40'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
         end
         for (int k = 0; k < 16; k++) begin
            pick = $urandom_range(0, 99);
            if (phase == 3 && k == 8) begin
               drain();
            end
            if (pick < 25) begin
               issue(REQ_ADVANCE, 0);
            end else if (pick < 55) begin
               do idx = $urandom_range(0, ATOMS - 1); while (!loaded[idx]);
               if ($urandom_range(0, 1) == 1) begin
                  idx = $urandom_range(0, n - 1);
               end
               issue(REQ_READ, idx);
            end else if (pick < 70) begin
               issue(REQ_LOAD, $urandom_range(0, ATOMS - 1));
            end else if (pick < 93) begin
               load_atom($urandom_range(0, n - 1), rand64() % box, rand64() >> 40);
            end else begin
               issue(2'd3, $urandom_range(0, ATOMS - 1));
            end
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_ATOM_COUNT;
      csr_wdata   = '0;
      burst_left  = 0;
      reg_count   = 13'd4096;
      reg_box     = 37'h10_0000_0000;
      reg_rest    = 27'd16777216;
      reg_k1      = 29'd16777216;
      reg_k2      = 30'd1677722;
      reg_dt      = 25'd167772;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_load_read();
      test_advance_edges();
      test_random_rings();
      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0 && energy_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
